FILE: sv/assert_macros.svh
// Assertion macros shared by the stripper RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/jcs_pkg.sv
// Shared types and constants for the JSONC comment stripper.
// No dependencies; imported by every module of the block.
package jcs_pkg;

    localparam int CHAR_W          = 21;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CHAR_W-1:0] CH_SLASH  = CHAR_W'(32'h2F);
    localparam logic [CHAR_W-1:0] CH_STAR   = CHAR_W'(32'h2A);
    localparam logic [CHAR_W-1:0] CH_NL     = CHAR_W'(32'h0A);
    localparam logic [CHAR_W-1:0] CH_QUOTE  = CHAR_W'(32'h22);
    localparam logic [CHAR_W-1:0] CH_BSLASH = CHAR_W'(32'h5C);

    // One classified request: an optional held slash, an optional character,
    // and the end-of-text mark. Neither slash nor char means a bare end beat.
    typedef struct packed {
        logic              slash;
        logic              chr_v;
        logic              last;
        logic [CHAR_W-1:0] chr;
    } t_entry;

endpackage

FILE: sv/jcs_front.sv
// Front end: scan-mode state machine that classifies each input character.
// Depends on jcs_pkg; feeds jcs_queue.
module jcs_front
    import jcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_last,
    output logic              o_push,
    output t_entry            o_entry
);

    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_SLASH      = 3'd1;
    localparam logic [2:0] MODE_STRING     = 3'd2;
    localparam logic [2:0] MODE_ESCAPE     = 3'd3;
    localparam logic [2:0] MODE_LINE       = 3'd4;
    localparam logic [2:0] MODE_BLOCK      = 3'd5;
    localparam logic [2:0] MODE_BLOCK_STAR = 3'd6;

    logic [2:0] r_mode;
    logic [2:0] n_mode;
    logic       w_slash;
    logic       w_chr_v;

    always_comb begin
        n_mode  = r_mode;
        w_slash = 1'b0;
        w_chr_v = 1'b0;
        unique case (r_mode)
            MODE_SLASH: begin
                n_mode = MODE_NORMAL;
                if (i_char == CH_SLASH) begin
                    n_mode = MODE_LINE;
                end else if (i_char == CH_STAR) begin
                    n_mode = MODE_BLOCK;
                end else begin
                    // held slash goes out, then the char as normal text
                    w_slash = 1'b1;
                    w_chr_v = 1'b1;
                    if (i_char == CH_QUOTE) begin
                        n_mode = MODE_STRING;
                    end
                end
            end
            MODE_STRING: begin
                w_chr_v = 1'b1;
                if (i_char == CH_BSLASH) begin
                    n_mode = MODE_ESCAPE;
                end else if (i_char == CH_QUOTE) begin
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_ESCAPE: begin
                n_mode  = MODE_STRING;
                w_chr_v = 1'b1;
            end
            MODE_LINE: begin
                if (i_char == CH_NL) begin
                    n_mode  = MODE_NORMAL;
                    w_chr_v = 1'b1;
                end
            end
            MODE_BLOCK: begin
                if (i_char == CH_STAR) begin
                    n_mode = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR: begin
                if (i_char == CH_SLASH) begin
                    n_mode = MODE_NORMAL;
                end else if (i_char != CH_STAR) begin
                    n_mode = MODE_BLOCK;
                end
            end
            default: begin
                n_mode = MODE_NORMAL;
                if (i_char == CH_SLASH) begin
                    if (i_last) begin
                        w_chr_v = 1'b1;
                    end else begin
                        n_mode = MODE_SLASH;
                    end
                end else begin
                    w_chr_v = 1'b1;
                    if (i_char == CH_QUOTE) begin
                        n_mode = MODE_STRING;
                    end
                end
            end
        endcase
        if (i_last) begin
            n_mode = MODE_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (i_accept) begin
            r_mode <= n_mode;
        end
    end

    // Items that produce nothing and do not end the text are dropped here.
    assign o_push        = i_accept && (w_chr_v || w_slash || i_last);
    assign o_entry.slash = w_slash;
    assign o_entry.chr_v = w_chr_v;
    assign o_entry.last  = i_last;
    assign o_entry.chr   = i_char;

endmodule

FILE: sv/jcs_queue.sv
// Short request queue between the front and back ends.
// Depends on jcs_pkg for the entry type.
module jcs_queue
    import jcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_wr,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_rd
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [IDX_W-1:0]   r_head;
    logic [IDX_W-1:0]   r_tail;
    logic [CNT_W-1:0]   r_count;
    logic               w_do_push;
    logic               w_do_pop;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] ptr);
        logic [IDX_W-1:0] nxt;
        if (ptr == IDX_W'(DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd      = r_mem[r_head];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_tail] <= i_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_tail <= f_next(r_tail);
            end
            if (w_do_pop) begin
                r_head <= f_next(r_head);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/jcs_back.sv
// Back end: expands queued requests into result beats and holds the
// output register. Depends on jcs_pkg; drains jcs_queue.
module jcs_back
    import jcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_entry            i_q_entry,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [CHAR_W-1:0] o_char_out,
    output logic              o_char_valid,
    output logic              o_end_of_text
);

    logic              r_full;
    logic              r_phase;   // slash beat of the head request already sent
    logic [CHAR_W-1:0] r_char;
    logic              r_valid;
    logic              r_eot;
    logic              w_load;
    logic              w_slash_beat;
    logic [CHAR_W-1:0] n_char;
    logic              n_valid;
    logic              n_eot;

    always_comb begin
        w_load       = (!r_full || i_pop) && i_q_valid;
        w_slash_beat = i_q_entry.slash && !r_phase;
        o_q_pop      = w_load && !(w_slash_beat && i_q_entry.chr_v);
        if (w_slash_beat) begin
            n_char  = CH_SLASH;
            n_valid = 1'b1;
            n_eot   = i_q_entry.last && !i_q_entry.chr_v;
        end else begin
            n_char  = i_q_entry.chr_v ? i_q_entry.chr : '0;
            n_valid = i_q_entry.chr_v;
            n_eot   = i_q_entry.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (w_load) begin
                r_full  <= 1'b1;
                r_phase <= !o_q_pop;
            end else if (i_pop) begin
                r_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char  <= n_char;
            r_valid <= n_valid;
            r_eot   <= n_eot;
        end
    end

    assign o_empty       = !r_full;
    assign o_char_out    = r_char;
    assign o_char_valid  = r_valid;
    assign o_end_of_text = r_eot;

endmodule

FILE: sv/jsonc_comment_stripper.sv
// JSONC comment stripper, top level. Built from jcs_front, jcs_queue and
// jcs_back; uses jcs_pkg and assert_macros.svh.
//
// Takes one code point per request and removes // line comments and
// /* */ block comments, passing string literals (with backslash escapes)
// through untouched. The newline ending a line comment is kept. A slash
// outside a string is held until the next character shows whether it opens
// a comment; if not, the slash and that character come out as two results.
// An unterminated block comment swallows the rest of the text. The request
// marked last closes the text: a held slash is flushed, the final result
// carries end_of_text, and if the last request produced no character a
// single result with char_valid low and char_out zero is returned. The
// scanner then starts over for the next text.
// Rate: one input request per cycle while full is low, no bubbles; the
// front end classifies combinationally and pushes into a QUEUE_DEPTH-entry
// queue. The back end sends one result per cycle while results are popped,
// so a request that flushes a held slash yields two results; full only
// rises when such pairs or a stalled pop back the queue up. An accepted
// request passes the queue, then the output register, on to the ports.
// Results sit in an output register, so input is taken while a result waits.
// Reset is synchronous and clears all control state.
`include "assert_macros.svh"

module jsonc_comment_stripper
    import jcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input side
    input  logic              push,
    output logic              full,
    input  logic [CHAR_W-1:0] i_char_in,
    input  logic              i_last_in,
    // result side
    output logic              empty,
    input  logic              pop,
    output logic [CHAR_W-1:0] o_char_out,
    output logic              o_char_valid,
    output logic              o_end_of_text
);

    logic   w_accept;
    logic   q_push;
    t_entry q_wr;
    logic   q_full;
    logic   q_valid;
    t_entry q_rd;
    logic   q_pop;

    assign w_accept = push && !q_full;
    assign full     = q_full;

    // Front: mode tracking and classification of each character
    jcs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_char   (i_char_in),
        .i_last   (i_last_in),
        .o_push   (q_push),
        .o_entry  (q_wr)
    );

    // Decoupling queue; lets the back end send both results of a slash pair
    jcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rd    (q_rd)
    );

    // Back: beat expansion and output register
    jcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_rd),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_char_out    (o_char_out),
        .o_char_valid  (o_char_valid),
        .o_end_of_text (o_end_of_text)
    );

    // Checks
    `ASSERT_CLK(a_deq_nonempty, i_clk, i_rst_n,
        q_pop |-> q_valid, "dequeue from empty queue")
    `ASSERT_CLK(a_slash_has_char, i_clk, i_rst_n,
        (q_push && q_wr.slash) |-> q_wr.chr_v, "flushed slash without following char")
    `ASSERT_CLK(a_blank_is_zero, i_clk, i_rst_n,
        (!empty && !o_char_valid) |-> (o_char_out == '0), "blank result carries nonzero char")
    `ASSERT_ALWAYS(a_empty_after_rst, i_clk,
        $past(!i_rst_n) |-> empty, "result pending right after reset")

endmodule
